// File: src/box_screen_column_range_core_assert.svh
// Assertion shorthands for the column range core.
`ifndef BOX_SCREEN_COLUMN_RANGE_CORE_ASSERT_SVH
`define BOX_SCREEN_COLUMN_RANGE_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BSCR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define BSCR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/bscr_pkg.sv
package bscr_pkg;

	localparam int FRAC_BITS = 8;
	localparam int VIEW_COLS = 256;
	localparam int COORD_W   = 16;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int VEC_W     = 11;
	localparam int PROD_W    = DIFF_W + VEC_W;
	localparam int SUM_W     = PROD_W + 2;
	localparam int EXT_W     = SUM_W - FRAC_BITS;
	localparam int DEN_W     = EXT_W - 1;
	localparam int NUM_W     = EXT_W + VEC_W;
	localparam int RES_W     = NUM_W + 2;
	localparam int COL_W     = 8;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		REG_VIEWER_X  = 3'd0,
		REG_VIEWER_Y  = 3'd1,
		REG_FORWARD_X = 3'd2,
		REG_FORWARD_Y = 3'd3,
		REG_NEAR      = 3'd4,
		REG_SCALE     = 3'd5,
		REG_CENTER    = 3'd6,
		REG_MARGIN    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] viewer_x;
		logic signed [15:0] viewer_y;
		logic signed [9:0]  forward_x;
		logic signed [9:0]  forward_y;
		logic [14:0]        near_depth;
		logic [9:0]         projection_scale;
		logic [7:0]         view_center;
		logic [3:0]         column_margin;
	} cfg_t;

	// One classified box waiting for its two divisions.
	typedef struct packed {
		logic                    full;
		logic                    rej;
		logic signed [NUM_W-1:0] num_lo;
		logic signed [NUM_W-1:0] num_hi;
		logic [DEN_W-1:0]        den_lo;
		logic [DEN_W-1:0]        den_hi;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic             neg;
		logic [DEN_W-1:0] den;
		logic [DEN_W-1:0] rem;
		logic [NUM_W-1:0] dq;
	} div_t;

	typedef struct packed {
		logic full;
		logic rej;
		div_t lo;
		div_t hi;
	} dstage_t;

endpackage

// File: src/bscr_front.sv
module bscr_front
	import bscr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] box_min_x,
	input  logic signed [15:0] box_max_x,
	input  logic signed [15:0] box_min_y,
	input  logic signed [15:0] box_max_y,
	input  q_stat_t            q_stat,
	output logic               q_push,
	output job_t               q_data
);

	logic                     en;
	logic signed [DIFF_W-1:0] relx, rely, spx, spy;
	logic signed [VEC_W-1:0]  fx, fy, rx, ry;
	logic                     full_c;

	logic                     v_s1, full_s1;
	logic signed [PROD_W-1:0] dpa_s1, dpb_s1, lta_s1, ltb_s1;
	logic signed [PROD_W-1:0] ddx_s1, ddy_s1, ldx_s1, ldy_s1;

	logic signed [SUM_W-1:0]  dep, lat, e_ddx, e_ddy, e_ldx, e_ldy;
	logic signed [SUM_W-1:0]  maxd_sum, mind_sum, minl_sum, maxl_sum;
	logic signed [EXT_W-1:0]  maxd, mind, minl, maxl, nearv, mind_c;

	logic                     v_s2, full_s2, rej_s2;
	logic signed [EXT_W-1:0]  minl_s2, maxl_s2, dlo_s2, dhi_s2;

	logic                     v_s3;
	job_t                     job_s3;
	logic signed [VEC_W-1:0]  scl;

	assign en       = !(v_s3 && q_stat.full);
	assign in_ready = en;
	assign q_push   = v_s3 && !q_stat.full;
	assign q_data   = job_s3;

	always_comb begin
		relx = $signed({box_min_x[15], box_min_x}) - $signed({cfg.viewer_x[15], cfg.viewer_x});
		rely = $signed({box_min_y[15], box_min_y}) - $signed({cfg.viewer_y[15], cfg.viewer_y});
		spx  = $signed({box_max_x[15], box_max_x}) - $signed({box_min_x[15], box_min_x});
		spy  = $signed({box_max_y[15], box_max_y}) - $signed({box_min_y[15], box_min_y});
		fx   = $signed({cfg.forward_x[9], cfg.forward_x});
		fy   = $signed({cfg.forward_y[9], cfg.forward_y});
		rx   = -fy;
		ry   = fx;
		full_c = (box_min_x > box_max_x) || (box_min_y > box_max_y) ||
			(cfg.viewer_x >= box_min_x && cfg.viewer_x <= box_max_x &&
			 cfg.viewer_y >= box_min_y && cfg.viewer_y <= box_max_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			full_s1 <= full_c;
			dpa_s1  <= relx * fx;
			dpb_s1  <= rely * fy;
			lta_s1  <= relx * rx;
			ltb_s1  <= rely * ry;
			ddx_s1  <= spx * fx;
			ddy_s1  <= spy * fy;
			ldx_s1  <= spx * rx;
			ldy_s1  <= spy * ry;
		end
	end

	// corner extrema: the span terms pick their sign per axis
	always_comb begin
		dep   = SUM_W'(dpa_s1) + SUM_W'(dpb_s1);
		lat   = SUM_W'(lta_s1) + SUM_W'(ltb_s1);
		e_ddx = SUM_W'(ddx_s1);
		e_ddy = SUM_W'(ddy_s1);
		e_ldx = SUM_W'(ldx_s1);
		e_ldy = SUM_W'(ldy_s1);
		maxd_sum = dep + (e_ddx < 0 ? '0 : e_ddx) + (e_ddy < 0 ? '0 : e_ddy);
		mind_sum = dep + (e_ddx < 0 ? e_ddx : '0) + (e_ddy < 0 ? e_ddy : '0);
		minl_sum = lat + (e_ldx < 0 ? e_ldx : '0) + (e_ldy < 0 ? e_ldy : '0);
		maxl_sum = lat + (e_ldx < 0 ? '0 : e_ldx) + (e_ldy < 0 ? '0 : e_ldy);
		maxd = EXT_W'(maxd_sum >>> FRAC_BITS);
		mind = EXT_W'(mind_sum >>> FRAC_BITS);
		minl = EXT_W'(minl_sum >>> FRAC_BITS);
		maxl = EXT_W'(maxl_sum >>> FRAC_BITS);
		nearv  = (cfg.near_depth == '0) ? EXT_W'(1) : $signed(EXT_W'(cfg.near_depth));
		mind_c = (mind < nearv) ? nearv : mind;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			full_s2 <= full_s1;
			rej_s2  <= !full_s1 && (maxd < nearv);
			minl_s2 <= minl;
			maxl_s2 <= maxl;
			dlo_s2  <= (minl < 0) ? mind_c : maxd;
			dhi_s2  <= (maxl > 0) ? mind_c : maxd;
		end
	end

	assign scl = $signed({1'b0, cfg.projection_scale});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			job_s3.full   <= full_s2;
			job_s3.rej    <= rej_s2;
			job_s3.num_lo <= minl_s2 * scl;
			job_s3.num_hi <= maxl_s2 * scl;
			job_s3.den_lo <= dlo_s2[DEN_W-1:0];
			job_s3.den_hi <= dhi_s2[DEN_W-1:0];
		end
	end

endmodule

// File: src/bscr_queue.sv
module bscr_queue
	import bscr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    wdata,
	input  logic    pop,
	output job_t    rdata,
	output q_stat_t stat
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   cnt_q;

	assign stat.full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rdata      = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: src/bscr_back.sv
module bscr_back
	import bscr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  q_stat_t          q_stat,
	input  job_t             q_data,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             visible,
	output logic [COL_W-1:0] left_col,
	output logic [COL_W-1:0] right_col
);

	logic    en;
	logic    v_q  [1:NUM_W];
	logic    v_in [NUM_W];
	dstage_t st_q [1:NUM_W];
	dstage_t st_in [NUM_W];
	dstage_t st_nx [NUM_W];
	dstage_t init;

	logic                    out_valid_q, vis_q;
	logic [COL_W-1:0]        lcol_q, rcol_q;
	logic signed [RES_W-1:0] qlo, qhi, lo, hi, ctr, mrg;
	dstage_t                 fin;

	assign en    = !out_valid_q || out_ready;
	assign q_pop = en && !q_stat.empty;

	function automatic div_t prep(input logic signed [NUM_W-1:0] n, input logic [DEN_W-1:0] d);
		div_t r;
		r.neg = n[NUM_W-1];
		r.den = d;
		r.rem = '0;
		r.dq  = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
		return r;
	endfunction

	// one restoring step: one quotient bit per stage
	function automatic div_t step(input div_t s);
		div_t             r;
		logic [DEN_W:0]   t;
		logic             ge;
		t  = {s.rem, s.dq[NUM_W-1]};
		ge = (t >= {1'b0, s.den});
		r      = s;
		r.rem  = ge ? DEN_W'(t - {1'b0, s.den}) : t[DEN_W-1:0];
		r.dq   = {s.dq[NUM_W-2:0], ge};
		return r;
	endfunction

	always_comb begin
		init.full = q_data.full;
		init.rej  = q_data.rej;
		init.lo   = prep(q_data.num_lo, q_data.den_lo);
		init.hi   = prep(q_data.num_hi, q_data.den_hi);
	end

	genvar k;
	generate
		for (k = 0; k < NUM_W; k++) begin : g_div
			if (k == 0) begin : g_first
				assign st_in[k] = init;
				assign v_in[k]  = q_pop;
			end else begin : g_rest
				assign st_in[k] = st_q[k];
				assign v_in[k]  = v_q[k];
			end

			always_comb begin
				st_nx[k]    = st_in[k];
				st_nx[k].lo = step(st_in[k].lo);
				st_nx[k].hi = step(st_in[k].hi);
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_q[k+1] <= 1'b0;
				end else if (en) begin
					v_q[k+1] <= v_in[k];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					st_q[k+1] <= st_nx[k];
				end
			end
		end
	endgenerate

	always_comb begin
		fin = st_q[NUM_W];
		qlo = $signed(RES_W'(fin.lo.dq));
		qhi = $signed(RES_W'(fin.hi.dq));
		if (fin.lo.neg) qlo = -qlo;
		if (fin.hi.neg) qhi = -qhi;
		ctr = $signed(RES_W'(cfg.view_center));
		mrg = $signed(RES_W'(cfg.column_margin));
		lo  = ctr + qlo - mrg;
		hi  = ctr + qhi + mrg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_q[NUM_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_q[NUM_W]) begin
			if (fin.full) begin
				vis_q  <= 1'b1;
				lcol_q <= '0;
				rcol_q <= COL_W'(VIEW_COLS - 1);
			end else if (fin.rej || hi < 0 || lo >= RES_W'(VIEW_COLS)) begin
				vis_q  <= 1'b0;
				lcol_q <= '0;
				rcol_q <= '0;
			end else begin
				vis_q  <= 1'b1;
				lcol_q <= (lo < 0) ? '0 : lo[COL_W-1:0];
				rcol_q <= (hi >= RES_W'(VIEW_COLS)) ? COL_W'(VIEW_COLS - 1) : hi[COL_W-1:0];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign visible   = vis_q;
	assign left_col  = lcol_q;
	assign right_col = rcol_q;

endmodule

// File: src/box_screen_column_range_core.sv
// Screen column cull for axis-aligned map boxes. Each input transaction carries one box;
// each output transaction gives visible plus an inclusive column range [left_col, right_col]
// that conservatively covers the box as seen from the viewer programmed over APB. Empty
// boxes and boxes containing the viewer come back visible with the full view; rejected
// boxes come back with visible low and both columns zero. A new box is taken every cycle
// while the queue has room. A box passes the front stages (corner products, depth/lateral
// extrema, lateral scaling), passes through the 4-entry queue, runs through the two
// restoring dividers (one quotient bit per stage) and leaves through one output register;
// throughput is one box per clock while out_ready holds.
// Registers sit at byte address 4*index; write them only while the core is idle.

`include "box_screen_column_range_core_assert.svh"

module box_screen_column_range_core
	import bscr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// APB config port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// box input
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] box_min_x,
	input  logic signed [15:0] box_max_x,
	input  logic signed [15:0] box_min_y,
	input  logic signed [15:0] box_max_y,
	// column range output
	output logic               out_valid,
	input  logic               out_ready,
	output logic               visible,
	output logic [7:0]         left_col,
	output logic [7:0]         right_col
);

	cfg_t     cfg_q;
	reg_idx_t ridx;
	logic     wr_en;

	q_stat_t  q_stat;
	logic     q_push, q_pop;
	job_t     q_wdata, q_rdata;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;

	// register file: written in the APB access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.viewer_x         <= '0;
			cfg_q.viewer_y         <= '0;
			cfg_q.forward_x        <= 10'sd256;
			cfg_q.forward_y        <= '0;
			cfg_q.near_depth       <= 15'd8;
			cfg_q.projection_scale <= 10'd128;
			cfg_q.view_center      <= 8'd128;
			cfg_q.column_margin    <= 4'd1;
		end else if (wr_en) begin
			unique case (ridx)
				REG_VIEWER_X:  cfg_q.viewer_x         <= pwdata[15:0];
				REG_VIEWER_Y:  cfg_q.viewer_y         <= pwdata[15:0];
				REG_FORWARD_X: cfg_q.forward_x        <= pwdata[9:0];
				REG_FORWARD_Y: cfg_q.forward_y        <= pwdata[9:0];
				REG_NEAR:      cfg_q.near_depth       <= pwdata[14:0];
				REG_SCALE:     cfg_q.projection_scale <= pwdata[9:0];
				REG_CENTER:    cfg_q.view_center      <= pwdata[7:0];
				REG_MARGIN:    cfg_q.column_margin    <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// readback: raw register bits, zero extended
	always_comb begin
		unique case (ridx)
			REG_VIEWER_X:  prdata = 32'(unsigned'(cfg_q.viewer_x));
			REG_VIEWER_Y:  prdata = 32'(unsigned'(cfg_q.viewer_y));
			REG_FORWARD_X: prdata = 32'(unsigned'(cfg_q.forward_x));
			REG_FORWARD_Y: prdata = 32'(unsigned'(cfg_q.forward_y));
			REG_NEAR:      prdata = 32'(cfg_q.near_depth);
			REG_SCALE:     prdata = 32'(cfg_q.projection_scale);
			REG_CENTER:    prdata = 32'(cfg_q.view_center);
			REG_MARGIN:    prdata = 32'(cfg_q.column_margin);
			default:       prdata = '0;
		endcase
	end

	// front: classify and form numerators/denominators
	bscr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.box_min_x (box_min_x),
		.box_max_x (box_max_x),
		.box_min_y (box_min_y),
		.box_max_y (box_max_y),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	// decouples front stalls from output backpressure
	bscr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	// back: divide, centre, widen, clamp
	bscr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_stat    (q_stat),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.visible   (visible),
		.left_col  (left_col),
		.right_col (right_col)
	);

	`BSCR_ASSERT_IMP(a_rej_cols_zero, out_valid && !visible, left_col == 8'd0 && right_col == 8'd0, "rejected box carries columns")
	`BSCR_ASSERT_IMP(a_stall_only_full, !in_ready, q_stat.full, "front stalled with queue room")
	`BSCR_ASSERT_IMP(a_q_flags, q_stat.full, !q_stat.empty, "queue full and empty at once")
	`BSCR_ASSERT_NXT(a_push_fills, q_push && !q_pop, !q_stat.empty, "pushed entry lost")

endmodule
